### hdl/rmq_pkg.sv
`timescale 1ns / 1ps

package rmq_pkg;

	// number format
	localparam int FRAC_BITS = 16;
	localparam int FW        = 18;               // field width
	localparam int VW        = FW + 2;           // signed pivot / pair-sum width
	localparam int MW        = VW - 1;           // magnitude width

	// square root of pivot << FRAC_BITS
	localparam int SQW       = 2 * ((MW + FRAC_BITS + 1) / 2);
	localparam int RW        = SQW / 2;          // root width
	localparam int REMW      = RW + 3;           // root remainder width
	localparam int SQ_STAGES = RW / 2;           // two root bits per stage

	// rounded quotient (mag << (FRAC_BITS-1)) + R/2 over R
	localparam int DW        = MW + FRAC_BITS;   // numerator width
	localparam int QW        = FW;               // quotient bits kept
	localparam int DV_STAGES = QW / 2;           // two quotient bits per stage

	localparam int LATENCY   = SQ_STAGES + DV_STAGES + 3;

	localparam logic [QW-1:0] OUT_MAX = QW'(131071);
	localparam logic [QW-1:0] OUT_MIN = QW'(131072);

	// which component carries the pivot
	typedef enum logic [1:0] {
		PIV_X,
		PIV_Y,
		PIV_Z,
		PIV_W
	} piv_t;

	// data riding along the root pipeline
	typedef struct packed {
		logic               inv;
		logic [3:0]         sgn;
		logic [3:0][MW-1:0] mag;
	} side_t;

	function automatic logic signed [VW-1:0] sx(input logic signed [FW-1:0] a);
		sx = VW'(a);
	endfunction

endpackage

### hdl/rotation_matrix_to_quaternion_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake           payload
// command   in   start, busy         m_r0c0 .. m_r2c2
// result    out  done (1 cycle)      quat_x, quat_y, quat_z, quat_w, invalid
//
// One item per cycle; busy stays low, so every start is taken.
// The pipeline has one case/pivot stage, nine root stages (two root bits
// each), one rounding stage, nine divide stages (two quotient bits each, four
// lanes) and the output register.
// Reset clears the valid bits only. Results cannot be held off by the receiver.
module rotation_matrix_to_quaternion_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [rmq_pkg::FW-1:0] m_r0c0,
	input  logic signed [rmq_pkg::FW-1:0] m_r0c1,
	input  logic signed [rmq_pkg::FW-1:0] m_r0c2,
	input  logic signed [rmq_pkg::FW-1:0] m_r1c0,
	input  logic signed [rmq_pkg::FW-1:0] m_r1c1,
	input  logic signed [rmq_pkg::FW-1:0] m_r1c2,
	input  logic signed [rmq_pkg::FW-1:0] m_r2c0,
	input  logic signed [rmq_pkg::FW-1:0] m_r2c1,
	input  logic signed [rmq_pkg::FW-1:0] m_r2c2,
	output logic                          done,
	output logic signed [rmq_pkg::FW-1:0] quat_x,
	output logic signed [rmq_pkg::FW-1:0] quat_y,
	output logic signed [rmq_pkg::FW-1:0] quat_z,
	output logic signed [rmq_pkg::FW-1:0] quat_w,
	output logic                          invalid
);
	import rmq_pkg::*;

	localparam logic signed [VW-1:0] ONE = VW'(1) <<< FRAC_BITS;

	assign busy = 1'b0;

	// ---------------- case select, pivot and pair sums ----------------
	logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [VW-1:0] t_c;
	logic signed [VW-1:0] v_c [4];
	piv_t                 piv_c;
	side_t                side_c;

	always_comb begin
		e00 = sx(m_r0c0); e01 = sx(m_r0c1); e02 = sx(m_r0c2);
		e10 = sx(m_r1c0); e11 = sx(m_r1c1); e12 = sx(m_r1c2);
		e20 = sx(m_r2c0); e21 = sx(m_r2c1); e22 = sx(m_r2c2);
		if (e22 < 0) begin
			piv_c = (e00 > e11) ? PIV_X : PIV_Y;
		end else begin
			piv_c = (e00 < -e11) ? PIV_Z : PIV_W;
		end
		unique case (piv_c)
			PIV_X: begin
				t_c = ONE + e00 - e11 - e22;
				v_c[0] = t_c; v_c[1] = e01 + e10; v_c[2] = e20 + e02; v_c[3] = e12 - e21;
			end
			PIV_Y: begin
				t_c = ONE - e00 + e11 - e22;
				v_c[0] = e01 + e10; v_c[1] = t_c; v_c[2] = e12 + e21; v_c[3] = e20 - e02;
			end
			PIV_Z: begin
				t_c = ONE - e00 - e11 + e22;
				v_c[0] = e20 + e02; v_c[1] = e12 + e21; v_c[2] = t_c; v_c[3] = e01 - e10;
			end
			default: begin
				t_c = ONE + e00 + e11 + e22;
				v_c[0] = e12 - e21; v_c[1] = e20 - e02; v_c[2] = e01 - e10; v_c[3] = t_c;
			end
		endcase
		side_c.inv = (t_c <= 0);
		for (int i = 0; i < 4; i++) begin
			side_c.sgn[i] = v_c[i][VW-1];
			side_c.mag[i] = v_c[i][VW-1] ? MW'(-v_c[i]) : MW'(v_c[i]);
		end
	end

	logic          vld_s1;
	side_t         side_s1;
	logic [MW-1:0] tmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_c;
		tmag_s1 <= side_c.inv ? '0 : MW'(t_c);
	end

	// ---------------- square root pipeline ----------------
	logic            sq_vld_s  [SQ_STAGES+1];
	side_t           sq_side_s [SQ_STAGES+1];
	logic [SQW-1:0]  sq_rad_s  [SQ_STAGES+1];
	logic [REMW-1:0] sq_rem_s  [SQ_STAGES+1];
	logic [RW-1:0]   sq_root_s [SQ_STAGES+1];

	assign sq_vld_s[0]  = vld_s1;
	assign sq_side_s[0] = side_s1;
	assign sq_rad_s[0]  = SQW'({tmag_s1, {FRAC_BITS{1'b0}}});
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;

	for (genvar k = 1; k <= SQ_STAGES; k++) begin : g_sq
		logic [SQW-1:0]  rad_c;
		logic [REMW-1:0] rem_c;
		logic [RW-1:0]   root_c;

		// two restoring root steps
		always_comb begin
			logic [REMW-1:0] rem2;
			logic [REMW-1:0] trial;
			rad_c  = sq_rad_s[k-1];
			rem_c  = sq_rem_s[k-1];
			root_c = sq_root_s[k-1];
			for (int j = 0; j < 2; j++) begin
				rem2  = {rem_c[REMW-3:0], rad_c[SQW-1 -: 2]};
				trial = REMW'({root_c, 2'b01});
				if (rem2 >= trial) begin
					rem_c  = rem2 - trial;
					root_c = {root_c[RW-2:0], 1'b1};
				end else begin
					rem_c  = rem2;
					root_c = {root_c[RW-2:0], 1'b0};
				end
				rad_c = rad_c << 2;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k] <= 1'b0;
			end else begin
				sq_vld_s[k] <= sq_vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			sq_side_s[k] <= sq_side_s[k-1];
			sq_rad_s[k]  <= rad_c;
			sq_rem_s[k]  <= rem_c;
			sq_root_s[k] <= root_c;
		end
	end

	// ---------------- rounding offset and overflow check ----------------
	logic               dv_vld_s  [DV_STAGES+1];
	logic               dv_inv_s  [DV_STAGES+1];
	logic [3:0]         dv_sgn_s  [DV_STAGES+1];
	logic [3:0]         dv_ovf_s  [DV_STAGES+1];
	logic [RW-1:0]      dv_r_s    [DV_STAGES+1];
	logic [3:0][RW-1:0] dv_rem_s  [DV_STAGES+1];
	logic [3:0][QW-1:0] dv_q_s    [DV_STAGES+1];

	logic [RW-1:0]      r_c;
	logic [3:0]         ovf_c;
	logic [3:0][RW-1:0] rem0_c;
	logic [3:0][QW-1:0] q0_c;

	always_comb begin
		logic [DW-1:0] d;
		r_c = sq_root_s[SQ_STAGES];
		for (int i = 0; i < 4; i++) begin
			d = DW'({sq_side_s[SQ_STAGES].mag[i], {(FRAC_BITS-1){1'b0}}}) + DW'(r_c >> 1);
			ovf_c[i]  = ((RW+QW)'(d) >= {r_c, {QW{1'b0}}});
			rem0_c[i] = RW'(d[DW-1:QW]);
			q0_c[i]   = d[QW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= sq_vld_s[SQ_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		dv_inv_s[0] <= sq_side_s[SQ_STAGES].inv;
		dv_sgn_s[0] <= sq_side_s[SQ_STAGES].sgn;
		dv_ovf_s[0] <= ovf_c;
		dv_r_s[0]   <= r_c;
		dv_rem_s[0] <= rem0_c;
		dv_q_s[0]   <= q0_c;
	end

	// ---------------- divide pipeline, four lanes ----------------
	for (genvar k = 1; k <= DV_STAGES; k++) begin : g_dv
		logic [3:0][RW-1:0] rem_c;
		logic [3:0][QW-1:0] q_c;

		// two restoring divide steps per lane
		always_comb begin
			logic [RW:0] rem2;
			rem_c = dv_rem_s[k-1];
			q_c   = dv_q_s[k-1];
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 2; j++) begin
					rem2 = {rem_c[i], q_c[i][QW-1]};
					if (rem2 >= {1'b0, dv_r_s[k-1]}) begin
						rem_c[i] = RW'(rem2 - {1'b0, dv_r_s[k-1]});
						q_c[i]   = {q_c[i][QW-2:0], 1'b1};
					end else begin
						rem_c[i] = RW'(rem2);
						q_c[i]   = {q_c[i][QW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			dv_inv_s[k] <= dv_inv_s[k-1];
			dv_sgn_s[k] <= dv_sgn_s[k-1];
			dv_ovf_s[k] <= dv_ovf_s[k-1];
			dv_r_s[k]   <= dv_r_s[k-1];
			dv_rem_s[k] <= rem_c;
			dv_q_s[k]   <= q_c;
		end
	end

	// ---------------- saturate, sign and output register ----------------
	logic [3:0][FW-1:0] res_c;

	always_comb begin
		logic [QW-1:0] q;
		for (int i = 0; i < 4; i++) begin
			q = dv_q_s[DV_STAGES][i];
			if (dv_inv_s[DV_STAGES]) begin
				res_c[i] = '0;
			end else if (dv_sgn_s[DV_STAGES][i]) begin
				res_c[i] = (dv_ovf_s[DV_STAGES][i] || q > OUT_MIN) ? OUT_MIN : FW'(-q);
			end else begin
				res_c[i] = (dv_ovf_s[DV_STAGES][i] || q > OUT_MAX) ? OUT_MAX : FW'(q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld_s[DV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		quat_x  <= res_c[0];
		quat_y  <= res_c[1];
		quat_z  <= res_c[2];
		quat_w  <= res_c[3];
		invalid <= dv_inv_s[DV_STAGES];
	end

`ifndef ASSERT_OFF
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching item");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && invalid |-> quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w == 0)
		else $error("invalid result with nonzero components");

	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[0] && !dv_inv_s[0] |-> dv_r_s[0] != 0)
		else $error("zero root for positive pivot");
`endif

endmodule
